// ===== design/strs_pkg.sv =====
// ----------------------------------------------------------------------------
// strs_pkg: shared types and constants of the sparse triangular row solver
// Number format, payload words of both channels and result status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package strs_pkg;

  localparam int VALUE_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int ROW_BITS   = 10;
  localparam int STAT_BITS  = 2;

  localparam logic [STAT_BITS-1:0] STATUS_OK       = 2'd0;
  localparam logic [STAT_BITS-1:0] STATUS_SAT      = 2'd1;
  localparam logic [STAT_BITS-1:0] STATUS_ZERO_DIV = 2'd2;

  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic [VALUE_BITS-1:0]        mag_t;

  typedef struct packed {
    logic [ROW_BITS-1:0] row_index;
    value_t              coefficient;
    logic [ROW_BITS-1:0] column_index;
    value_t              rhs_value;
    logic                first_of_row;
    logic                last_of_row;
  } entry_t;

  typedef struct packed {
    logic [ROW_BITS-1:0]  solved_row;
    value_t               solution;
    logic [STAT_BITS-1:0] status;
  } result_t;

  // Magnitude of a signed value; the most negative value maps to 2^(n-1).
  function automatic mag_t magnitude(input value_t x);
    mag_t m;
    m = x[VALUE_BITS-1] ? mag_t'(-x) : mag_t'(x);
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== design/sparse_triangular_row_solve.sv =====
// An off-diagonal word passes accept, memory read and accumulate, in order.
// A last word of a row has its divisor checked, then the bit-serial divider runs
// (skipped if the divisor is zero), then finish registers the result once the
// output is free. One word at a time is in work, until the sequencer is idle.
// Reset clears the sequencer, accumulator and output valid, not the solution memory.
// The user must ensure a word is read only after its row was solved (unenforced).
// ----------------------------------------------------------------------------
// sparse_triangular_row_solve: streamed sparse triangular row solver
// Accumulates coefficient times earlier solutions per row, divides by the
// diagonal, stores and emits the row's solution.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_triangular_row_solve #(
  parameter int ROW_COUNT = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              entry_valid,
  output logic                   entry_stall,
  input  wire strs_pkg::entry_t  entry,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output strs_pkg::result_t      result
);

  localparam int AW    = ROW_COUNT > 1 ? $clog2(ROW_COUNT) : 1;
  localparam int RB    = strs_pkg::ROW_BITS;
  localparam int CMP_W = (RB > AW ? RB : AW) + 1;
  localparam logic [CMP_W-1:0] ROW_LIMIT = CMP_W'(ROW_COUNT);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_READ   = 6'b000010,
    ST_ADD    = 6'b000100,
    ST_DSTART = 6'b001000,
    ST_DIV    = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t             state;
  strs_pkg::entry_t   cur;
  strs_pkg::value_t   acc;
  logic               row_sat;
  logic               col_ok;
  strs_pkg::value_t   answer;
  logic [strs_pkg::STAT_BITS-1:0] answer_status;

  logic               accept;
  logic               out_free;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic               wr_en;
  strs_pkg::value_t   rd_data;
  strs_pkg::value_t   word;
  strs_pkg::value_t   mac_sum;
  logic               mac_sat;
  logic               div_start;
  logic               div_busy;
  logic               div_done;
  strs_pkg::value_t   div_q;
  logic               div_sat;

  assign entry_stall = state != ST_IDLE;
  assign accept      = entry_valid && !entry_stall;
  assign out_free    = !result_valid || !result_stall;
  assign rd_addr     = AW'(entry.column_index);
  assign wr_addr     = AW'(cur.row_index);
  assign wr_en       = state == ST_FINISH && out_free && CMP_W'(cur.row_index) < ROW_LIMIT;
  assign word        = col_ok ? rd_data : '0;
  assign div_start   = state == ST_DSTART && cur.coefficient != '0;

  strs_ram #(
    .WIDTH(strs_pkg::VALUE_BITS),
    .DEPTH(ROW_COUNT)
  ) u_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(answer),
    .rd_en  (accept),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  strs_mac u_mac (
    .clk (clk),
    .load(state == ST_READ),
    .coef(cur.coefficient),
    .word(word),
    .acc (acc),
    .sum (mac_sum),
    .sat (mac_sat)
  );

  strs_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(acc),
    .divisor (cur.coefficient),
    .busy    (div_busy),
    .done    (div_done),
    .quotient(div_q),
    .sat     (div_sat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      acc          <= '0;
      row_sat      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (entry.first_of_row) begin
              acc     <= entry.rhs_value;
              row_sat <= 1'b0;
            end
            state <= entry.last_of_row ? ST_DSTART : ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_ADD;
        end
        ST_ADD: begin
          acc     <= mac_sum;
          row_sat <= row_sat | mac_sat;
          state   <= ST_IDLE;
        end
        ST_DSTART: begin
          state <= div_start ? ST_DIV : ST_FINISH;
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            result_valid <= 1'b1;
            acc          <= '0;
            row_sat      <= 1'b0;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur    <= entry;
      col_ok <= CMP_W'(entry.column_index) < ROW_LIMIT;
    end
    if (state == ST_DSTART && !div_start) begin
      answer        <= '0;
      answer_status <= strs_pkg::STATUS_ZERO_DIV;
    end else if (state == ST_DIV && div_done) begin
      answer        <= div_q;
      answer_status <= (row_sat || div_sat) ? strs_pkg::STATUS_SAT : strs_pkg::STATUS_OK;
    end
    if (state == ST_FINISH && out_free) begin
      result.solved_row <= cur.row_index;
      result.solution   <= answer;
      result.status     <= answer_status;
    end
  end

  // The divider only runs while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (rst) div_busy |-> state == ST_DIV)
    else $error("divider busy outside its state");

  // An accepted word always starts work, so input is held off next cycle.
  assert property (@(posedge clk) disable iff (rst) accept |=> entry_stall)
    else $error("accepted word did not start work");

  // A zero divisor always yields a zero solution.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == strs_pkg::STATUS_ZERO_DIV |-> result.solution == '0)
    else $error("zero divisor with nonzero solution");

  // Accumulation always follows a memory read.
  assert property (@(posedge clk) disable iff (rst)
    state == ST_ADD |-> $past(state) == ST_READ)
    else $error("accumulate without a read");

endmodule

`default_nettype wire

// ===== design/strs_ram.sv =====
// ----------------------------------------------------------------------------
// strs_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module strs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                                  clk,
  input  wire logic                                  wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                      wr_data,
  input  wire logic                                  rd_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== design/strs_mac.sv =====
// ----------------------------------------------------------------------------
// strs_mac: saturating fixed-point multiply and accumulate
// The product is registered; the saturating add against the accumulator
// follows in the next cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module strs_mac (
  input  wire logic             clk,
  input  wire logic             load,
  input  wire strs_pkg::value_t coef,
  input  wire strs_pkg::value_t word,
  input  wire strs_pkg::value_t acc,
  output strs_pkg::value_t      sum,
  output logic                  sat
);

  localparam int VW   = strs_pkg::VALUE_BITS;
  localparam int SH_W = 2 * VW - strs_pkg::FRAC_BITS;

  logic                 neg;
  logic [2*VW-1:0]      full;
  logic [SH_W-1:0]      shifted;
  logic [SH_W-1:0]      limit;
  logic                 over;
  strs_pkg::value_t     prod_c;
  strs_pkg::value_t     prod;
  logic                 prod_sat;
  logic signed [VW:0]   wide;
  logic                 add_over;

  always_comb begin
    neg     = coef[VW-1] ^ word[VW-1];
    full    = {{VW{1'b0}}, strs_pkg::magnitude(coef)} * {{VW{1'b0}}, strs_pkg::magnitude(word)};
    shifted = full[2*VW-1:strs_pkg::FRAC_BITS];
    limit   = (SH_W'(1) << (VW - 1)) - SH_W'(!neg);
    over    = shifted > limit;
    if (over) begin
      prod_c = neg ? strs_pkg::value_t'(-limit[VW-1:0]) : strs_pkg::value_t'(limit[VW-1:0]);
    end else begin
      prod_c = neg ? strs_pkg::value_t'(-shifted[VW-1:0])
                   : strs_pkg::value_t'(shifted[VW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prod     <= prod_c;
      prod_sat <= over;
    end
  end

  always_comb begin
    wide     = {acc[VW-1], acc} + {prod[VW-1], prod};
    add_over = wide[VW] != wide[VW-1];
    if (add_over) begin
      sum = acc[VW-1] ? strs_pkg::value_t'({1'b1, {(VW-1){1'b0}}})
                      : strs_pkg::value_t'({1'b0, {(VW-1){1'b1}}});
    end else begin
      sum = wide[VW-1:0];
    end
    sat = prod_sat | add_over;
  end

endmodule

`default_nettype wire

// ===== design/strs_div.sv =====
// ----------------------------------------------------------------------------
// strs_div: iterative fixed-point divider
// Restoring division of (dividend * 2^FRAC) by divisor, one quotient bit per
// cycle, truncating toward zero and saturating the result.
// ----------------------------------------------------------------------------
`default_nettype none

module strs_div (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire strs_pkg::value_t dividend,
  input  wire strs_pkg::value_t divisor,
  output logic                  busy,
  output logic                  done,
  output strs_pkg::value_t      quotient,
  output logic                  sat
);

  localparam int VW    = strs_pkg::VALUE_BITS;
  localparam int NUM_W = VW + strs_pkg::FRAC_BITS;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic              neg;
  strs_pkg::mag_t    md;
  logic [NUM_W-1:0]  num;
  logic [VW-1:0]     rem;
  logic [NUM_W-1:0]  q;
  logic [CNT_W-1:0]  count;
  logic [VW:0]       trial;
  logic              fits;
  logic [NUM_W-1:0]  limit;

  always_comb begin
    trial = {rem, num[NUM_W-1]};
    fits  = trial >= {1'b0, md};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(NUM_W);
      end else if (busy) begin
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[VW-1] ^ divisor[VW-1];
      md  <= strs_pkg::magnitude(divisor);
      num <= {strs_pkg::magnitude(dividend), {strs_pkg::FRAC_BITS{1'b0}}};
      rem <= '0;
      q   <= '0;
    end else if (busy) begin
      num <= num << 1;
      rem <= fits ? VW'(trial - {1'b0, md}) : trial[VW-1:0];
      q   <= {q[NUM_W-2:0], fits};
    end
  end

  always_comb begin
    limit = (NUM_W'(1) << (VW - 1)) - NUM_W'(!neg);
    sat   = q > limit;
    if (sat) begin
      quotient = neg ? strs_pkg::value_t'(-limit[VW-1:0])
                     : strs_pkg::value_t'(limit[VW-1:0]);
    end else begin
      quotient = neg ? strs_pkg::value_t'(-q[VW-1:0]) : strs_pkg::value_t'(q[VW-1:0]);
    end
  end

endmodule

`default_nettype wire
